/* rtl/csf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csf_pkg
// Shared types, character codes and helpers for the C source fragmenter.
// ----------------------------------------------------------------------------
package csf_pkg;

  localparam int POS_BITS   = 32;
  localparam int MAX_RES    = 3;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [31:0] LEN_MAX = 32'hFFFF_FFFF;

  localparam logic [2:0] KIND_COMMENT = 3'd0;
  localparam logic [2:0] KIND_PRE     = 3'd1;
  localparam logic [2:0] KIND_OPEN    = 3'd2;
  localparam logic [2:0] KIND_CLOSE   = 3'd3;
  localparam logic [2:0] KIND_CODE    = 3'd4;

  localparam logic [1:0] LIT_NONE   = 2'd0;
  localparam logic [1:0] LIT_STRING = 2'd1;
  localparam logic [1:0] LIT_CHAR   = 2'd2;
  localparam logic [1:0] LIT_CONT   = 2'd3;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;

  typedef enum logic [5:0] {
    MODE_IDLE  = 6'b000001,
    MODE_SLASH = 6'b000010,
    MODE_LINE  = 6'b000100,
    MODE_BLOCK = 6'b001000,
    MODE_PRE   = 6'b010000,
    MODE_CODE  = 6'b100000
  } mode_t;

  typedef enum logic [1:0] {
    ACT_MORE   = 2'd0,
    ACT_AFTER  = 2'd1,
    ACT_BEFORE = 2'd2
  } act_t;

  typedef struct packed {
    logic        frag_valid;
    logic [2:0]  frag_type;
    logic [31:0] frag_start;
    logic [31:0] frag_length;
    logic        end_of_text;
  } result_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
           (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

  function automatic logic is_brace(input logic [7:0] c);
    return (c == CH_LBRACE) || (c == CH_RBRACE);
  endfunction

  function automatic logic [31:0] pos_to_start(input logic [POS_BITS-1:0] p);
    logic [63:0] w;
    w = 64'(p);
    return w[31:0];
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] n);
    return (n == LEN_MAX) ? n : n + 32'd1;
  endfunction

endpackage

/* rtl/csf_scanner.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csf_scanner
// Scanner state and per-byte next-state logic; yields up to three results.
// ----------------------------------------------------------------------------
module csf_scanner import csf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] text_byte,
  input  logic       is_last,
  output result_t    res [MAX_RES],
  output logic [1:0] res_cnt
);

  typedef struct packed {
    logic [1:0] lit;
    logic       esc;
    logic       grow;
    act_t       act;
  } body_t;

  mode_t               mode_r, mode_nxt;
  logic [1:0]          lit_r, lit_nxt;
  logic                esc_r, esc_nxt;
  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic [POS_BITS-1:0] fst_r, fst_nxt;
  logic [2:0]          kind_r, kind_nxt;
  logic [31:0]         cnt_r, cnt_nxt;

  body_t       br_cur, br_new;
  logic        use_body;
  logic [31:0] grown;
  logic        e_open, e_brace, e_flush, e_mark;
  result_t     r_open, r_brace, r_flush, r_mark;
  logic [2:0]  idx;

  function automatic body_t body_step(input logic [7:0] c, input logic [1:0] lit,
                                      input logic esc, input logic pre);
    body_t b;
    logic  done;
    b.lit  = lit;
    b.esc  = esc;
    b.grow = 1'b0;
    b.act  = ACT_MORE;
    done   = 1'b0;
    if (lit == LIT_STRING || lit == LIT_CHAR) begin
      b.grow = 1'b1;
      done   = 1'b1;
      if (esc) begin
        b.esc = 1'b0;
      end else if (c == ((lit == LIT_STRING) ? CH_DQUOTE : CH_SQUOTE)) begin
        b.lit = LIT_NONE;
      end else if (c == CH_BSLASH) begin
        b.esc = 1'b1;
      end
    end else if (lit == LIT_CONT) begin
      if (esc) begin
        b.esc = 1'b0;
        b.lit = LIT_NONE;
        if (c == CH_LF) begin
          b.grow = 1'b1;
          done   = 1'b1;
        end
      end else if (c == CH_CR) begin
        b.esc  = 1'b1;
        b.grow = 1'b1;
        done   = 1'b1;
      end else if (c == CH_LF) begin
        b.lit  = LIT_NONE;
        b.grow = 1'b1;
        done   = 1'b1;
      end else if (is_blank(c)) begin
        b.grow = 1'b1;
        done   = 1'b1;
      end else begin
        b.lit = LIT_NONE;
      end
    end
    if (!done) begin
      if (c == CH_DQUOTE) begin
        b.lit  = LIT_STRING;
        b.esc  = 1'b0;
        b.grow = 1'b1;
      end else if (c == CH_SQUOTE) begin
        b.lit  = LIT_CHAR;
        b.esc  = 1'b0;
        b.grow = 1'b1;
      end else if (c == CH_BSLASH) begin
        b.lit  = LIT_CONT;
        b.esc  = 1'b0;
        b.grow = 1'b1;
      end else if (pre) begin
        if (c == CH_CR || c == CH_LF) begin
          b.act = ACT_BEFORE;
        end else begin
          b.grow = 1'b1;
        end
      end else if (c == CH_SEMI) begin
        b.grow = 1'b1;
        b.act  = ACT_AFTER;
      end else if (is_brace(c)) begin
        b.act = ACT_BEFORE;
      end else begin
        b.grow = 1'b1;
      end
    end
    return b;
  endfunction

  assign br_cur = body_step(text_byte, lit_r, esc_r, mode_r == MODE_PRE);
  assign br_new = body_step(text_byte, LIT_NONE, 1'b0, 1'b0);
  assign grown  = br_cur.grow ? sat_inc(cnt_r) : cnt_r;

  always_comb begin
    mode_nxt = mode_r;
    lit_nxt  = lit_r;
    esc_nxt  = esc_r;
    cnt_nxt  = cnt_r;
    kind_nxt = kind_r;
    fst_nxt  = fst_r;
    pos_nxt  = pos_r + POS_BITS'(1);
    use_body = 1'b0;
    e_open   = 1'b0;
    e_brace  = 1'b0;
    r_open   = '0;
    r_brace  = '0;
    r_flush  = '0;
    r_mark   = '0;

    r_open.frag_valid  = 1'b1;
    r_open.frag_type   = kind_r;
    r_open.frag_start  = pos_to_start(fst_r);
    r_open.frag_length = cnt_r;

    r_brace.frag_valid  = 1'b1;
    r_brace.frag_type   = (text_byte == CH_LBRACE) ? KIND_OPEN : KIND_CLOSE;
    r_brace.frag_start  = pos_to_start(pos_r);
    r_brace.frag_length = 32'd1;

    unique case (mode_r) inside
      MODE_SLASH: begin
        if (text_byte == CH_SLASH) begin
          mode_nxt = MODE_LINE;
          kind_nxt = KIND_COMMENT;
          cnt_nxt  = sat_inc(cnt_r);
        end else if (text_byte == CH_STAR) begin
          mode_nxt = MODE_BLOCK;
          kind_nxt = KIND_COMMENT;
          esc_nxt  = 1'b0;
          cnt_nxt  = sat_inc(cnt_r);
        end else begin
          mode_nxt = MODE_CODE;
          kind_nxt = KIND_CODE;
          use_body = 1'b1;
        end
      end
      MODE_LINE: begin
        if (text_byte == CH_CR || text_byte == CH_LF) begin
          e_open = 1'b1;
        end else begin
          cnt_nxt = sat_inc(cnt_r);
        end
      end
      MODE_BLOCK: begin
        if (esc_r && text_byte == CH_SLASH) begin
          e_open             = 1'b1;
          r_open.frag_length = sat_inc(cnt_r);
        end else begin
          cnt_nxt = sat_inc(cnt_r);
          esc_nxt = (text_byte == CH_STAR);
        end
      end
      MODE_PRE, MODE_CODE: begin
        use_body = 1'b1;
      end
      MODE_IDLE: begin
        if (is_blank(text_byte)) begin
          mode_nxt = MODE_IDLE;
        end else if (is_brace(text_byte)) begin
          e_brace = 1'b1;
        end else begin
          fst_nxt = pos_r;
          lit_nxt = LIT_NONE;
          esc_nxt = 1'b0;
          if (text_byte == CH_SLASH) begin
            mode_nxt = MODE_SLASH;
            kind_nxt = KIND_CODE;
            cnt_nxt  = 32'd1;
          end else if (text_byte == CH_HASH) begin
            mode_nxt = MODE_PRE;
            kind_nxt = KIND_PRE;
            cnt_nxt  = 32'd1;
          end else begin
            mode_nxt = MODE_CODE;
            kind_nxt = KIND_CODE;
            lit_nxt  = br_new.lit;
            esc_nxt  = br_new.esc;
            cnt_nxt  = br_new.grow ? 32'd1 : 32'd0;
            if (br_new.act == ACT_AFTER) begin
              e_open             = 1'b1;
              r_open.frag_type   = KIND_CODE;
              r_open.frag_start  = pos_to_start(pos_r);
              r_open.frag_length = br_new.grow ? 32'd1 : 32'd0;
            end
          end
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
      end
    endcase

    if (use_body) begin
      lit_nxt = br_cur.lit;
      esc_nxt = br_cur.esc;
      cnt_nxt = grown;
      if (br_cur.act != ACT_MORE) begin
        e_open             = 1'b1;
        r_open.frag_type   = kind_nxt;
        r_open.frag_length = grown;
        e_brace            = (br_cur.act == ACT_BEFORE) && is_brace(text_byte);
      end
    end

    // close the fragment: back to idle
    if (e_open) begin
      mode_nxt = MODE_IDLE;
      lit_nxt  = LIT_NONE;
      esc_nxt  = 1'b0;
      cnt_nxt  = 32'd0;
    end

    e_flush = is_last && (mode_nxt != MODE_IDLE);
    e_mark  = is_last;
    r_flush.frag_valid  = 1'b1;
    r_flush.frag_type   = kind_nxt;
    r_flush.frag_start  = pos_to_start(fst_nxt);
    r_flush.frag_length = cnt_nxt;
    r_mark.end_of_text  = 1'b1;

    if (is_last) begin
      mode_nxt = MODE_IDLE;
      lit_nxt  = LIT_NONE;
      esc_nxt  = 1'b0;
      cnt_nxt  = 32'd0;
      kind_nxt = KIND_COMMENT;
      fst_nxt  = '0;
      pos_nxt  = '0;
    end
  end

  // pack results in order: closed fragment, brace, flush, end marker
  always_comb begin
    for (int i = 0; i < MAX_RES; i++) begin
      res[i] = '0;
    end
    idx = 3'd0;
    if (e_open && idx < 3'(MAX_RES)) begin
      res[idx[1:0]] = r_open;
      idx = idx + 3'd1;
    end
    if (e_brace && idx < 3'(MAX_RES)) begin
      res[idx[1:0]] = r_brace;
      idx = idx + 3'd1;
    end
    if (e_flush && idx < 3'(MAX_RES)) begin
      res[idx[1:0]] = r_flush;
      idx = idx + 3'd1;
    end
    if (e_mark && idx < 3'(MAX_RES)) begin
      res[idx[1:0]] = r_mark;
      idx = idx + 3'd1;
    end
    res_cnt = idx[1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      lit_r  <= LIT_NONE;
      esc_r  <= 1'b0;
      pos_r  <= '0;
      fst_r  <= '0;
      kind_r <= KIND_COMMENT;
      cnt_r  <= 32'd0;
    end else if (step) begin
      mode_r <= mode_nxt;
      lit_r  <= lit_nxt;
      esc_r  <= esc_nxt;
      pos_r  <= pos_nxt;
      fst_r  <= fst_nxt;
      kind_r <= kind_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    step && is_last |=> mode_r == MODE_IDLE && pos_r == '0)
    else $error("scanner state not cleared after final byte");

  a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
    step && !is_last |=> pos_r == $past(pos_r) + POS_BITS'(1))
    else $error("byte position did not advance");

  a_last_marks: assert property (@(posedge clk) disable iff (!rst_n)
    step && is_last |-> res_cnt != 2'd0)
    else $error("final byte produced no end marker");

endmodule

/* rtl/csf_result_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csf_result_fifo
// Result queue: up to three writes per cycle, one read per cycle.
// ----------------------------------------------------------------------------
module csf_result_fifo import csf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_cnt,
  input  result_t    push_data [MAX_RES],
  output logic       has_room,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    out_data
);

  result_t            mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0] count_r;
  logic               pop;

  assign out_valid = (count_r != '0);
  assign out_data  = mem[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign has_room  = (count_r <= FIFO_CW'(FIFO_DEPTH - MAX_RES));

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (2'(i) < push_cnt) begin
        mem[wr_ptr_r + FIFO_AW'(i)] <= push_data[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + FIFO_AW'(push_cnt);
      rd_ptr_r <= rd_ptr_r + FIFO_AW'(pop);
      count_r  <= count_r + FIFO_CW'(push_cnt) - FIFO_CW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FIFO_CW'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_cnt != 2'd0 |-> count_r <= FIFO_CW'(FIFO_DEPTH - 32'(push_cnt)))
    else $error("push without room");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |->
      count_r == $past(count_r) + FIFO_CW'($past(push_cnt)) - FIFO_CW'($past(pop)))
    else $error("queue count mismatch");

endmodule

/* rtl/c_source_fragmenter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_source_fragmenter
// Cuts C source text, one byte per transaction, into comment, preprocessor,
// brace and code fragments, each reported with kind, start and length.
// ----------------------------------------------------------------------------
// Path: input stage register, then a scanner step pushes into the result queue.
// Throughput: one byte per cycle while the eight-entry result queue has room
// for three results; output drains one per cycle while out_ready is high.
// Reset: synchronous active-low rst_n empties the input stage and the queue
// and returns the scanner to idle at byte position zero.
module c_source_fragmenter import csf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_frag_valid,
  output logic [2:0]  out_frag_type,
  output logic [31:0] out_frag_start,
  output logic [31:0] out_frag_length,
  output logic        out_end_of_text
);

  logic       stg_valid_r;
  logic [7:0] stg_byte_r;
  logic       stg_last_r;
  logic       step;
  logic       has_room;
  result_t    res [MAX_RES];
  logic [1:0] res_cnt;
  logic [1:0] push_cnt;
  result_t    out_data;

  assign step     = stg_valid_r && has_room;
  assign in_ready = !stg_valid_r || step;
  assign push_cnt = step ? res_cnt : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ready) begin
      stg_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_byte_r <= in_text_byte;
      stg_last_r <= in_is_last;
    end
  end

  csf_scanner u_scanner (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .text_byte (stg_byte_r),
    .is_last   (stg_last_r),
    .res       (res),
    .res_cnt   (res_cnt)
  );

  csf_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push_data (res),
    .has_room  (has_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_frag_valid  = out_data.frag_valid;
  assign out_frag_type   = out_data.frag_type;
  assign out_frag_start  = out_data.frag_start;
  assign out_frag_length = out_data.frag_length;
  assign out_end_of_text = out_data.end_of_text;

endmodule
